[hdl/ctl_pkg.sv]
// Package for the C token lexer: token kinds, lexer classes, result struct.
// Used by every module of the lexer; depends on nothing.
package ctl_pkg;

    localparam int KIND_BITS = 7;
    localparam logic [6:0] KIND_NUM = 7'd35;
    localparam logic [6:0] KIND_ID  = 7'd36;
    localparam logic [6:0] KIND_KW0 = 7'd37;
    localparam logic [6:0] KIND_EOF = 7'd71;

    typedef enum logic [3:0] {
        PC_NONE  = 4'd0,  PC_NUM  = 4'd1,  PC_ID   = 4'd2,  PC_MINUS = 4'd3,
        PC_PLUS  = 4'd4,  PC_MUL  = 4'd5,  PC_DIV  = 4'd6,  PC_MOD   = 4'd7,
        PC_EQ    = 4'd8,  PC_LT   = 4'd9,  PC_SHL  = 4'd10, PC_GT    = 4'd11,
        PC_SHR   = 4'd12, PC_BANG = 4'd13, PC_AMP  = 4'd14, PC_BAR   = 4'd15
    } pclass_t;

    // One token in flight. Line and offset are held at the full field width.
    typedef struct packed {
        logic [6:0]  kind;
        logic [63:0] text;
        logic [3:0]  len;
        logic        trunc;
        logic [15:0] line;
        logic [19:0] offset;
        logic        last;
    } token_t;

    // Up to three tokens produced by one byte.
    typedef struct packed {
        logic [1:0] count;
        token_t     t0;
        token_t     t1;
        token_t     t2;
    } group_t;

    // Operator text for kinds 0..34, first byte lowest.
    function automatic logic [23:0] op_text(input logic [6:0] k);
        case (k)
            7'd0:  op_text = 24'h7B;     7'd1:  op_text = 24'h7D;
            7'd2:  op_text = 24'h28;     7'd3:  op_text = 24'h29;
            7'd4:  op_text = 24'h3B;     7'd5:  op_text = 24'h3D2D;
            7'd6:  op_text = 24'h2D2D;   7'd7:  op_text = 24'h2D;
            7'd8:  op_text = 24'h7E;     7'd9:  op_text = 24'h3D2B;
            7'd10: op_text = 24'h2B2B;   7'd11: op_text = 24'h2B;
            7'd12: op_text = 24'h3D2A;   7'd13: op_text = 24'h2A;
            7'd14: op_text = 24'h3D2F;   7'd15: op_text = 24'h2F;
            7'd16: op_text = 24'h3D25;   7'd17: op_text = 24'h25;
            7'd18: op_text = 24'h3D3D;   7'd19: op_text = 24'h3D;
            7'd20: op_text = 24'h3D3C;   7'd21: op_text = 24'h3D3C3C;
            7'd22: op_text = 24'h3C3C;   7'd23: op_text = 24'h3C;
            7'd24: op_text = 24'h3D3E;   7'd25: op_text = 24'h3D3E3E;
            7'd26: op_text = 24'h3E3E;   7'd27: op_text = 24'h3E;
            7'd28: op_text = 24'h3D21;   7'd29: op_text = 24'h21;
            7'd30: op_text = 24'h2626;   7'd31: op_text = 24'h26;
            7'd32: op_text = 24'h7C7C;   7'd33: op_text = 24'h7C;
            7'd34: op_text = 24'h5E;
            default: op_text = 24'h0;
        endcase
    endfunction

    function automatic logic [3:0] op_len(input logic [6:0] k);
        case (k)
            7'd21, 7'd25: op_len = 4'd3;
            7'd5, 7'd6, 7'd9, 7'd10, 7'd12, 7'd14, 7'd16, 7'd18, 7'd20,
            7'd22, 7'd24, 7'd26, 7'd28, 7'd30, 7'd32: op_len = 4'd2;
            default: op_len = 4'd1;
        endcase
    endfunction

    // Kind of an operator class flushed without a partner byte.
    function automatic logic [6:0] alone_kind(input pclass_t c);
        case (c)
            PC_MINUS: alone_kind = 7'd7;   PC_PLUS: alone_kind = 7'd11;
            PC_MUL:   alone_kind = 7'd13;  PC_DIV:  alone_kind = 7'd15;
            PC_MOD:   alone_kind = 7'd17;  PC_EQ:   alone_kind = 7'd19;
            PC_LT:    alone_kind = 7'd23;  PC_SHL:  alone_kind = 7'd22;
            PC_GT:    alone_kind = 7'd27;  PC_SHR:  alone_kind = 7'd26;
            PC_BANG:  alone_kind = 7'd29;  PC_AMP:  alone_kind = 7'd31;
            PC_BAR:   alone_kind = 7'd33;
            default:  alone_kind = 7'd0;
        endcase
    endfunction

    // Keyword lookup on packed text; returns identifier kind on no match.
    function automatic logic [6:0] kw_kind(input logic [63:0] t);
        case (t)
            64'h6F747561:         kw_kind = 7'd37;
            64'h6B61657262:       kw_kind = 7'd38;
            64'h65736163:         kw_kind = 7'd39;
            64'h72616863:         kw_kind = 7'd40;
            64'h74736E6F63:       kw_kind = 7'd41;
            64'h65756E69746E6F63: kw_kind = 7'd42;
            64'h746C7561666564:   kw_kind = 7'd43;
            64'h6F64:             kw_kind = 7'd44;
            64'h656C62756F64:     kw_kind = 7'd45;
            64'h65736C65:         kw_kind = 7'd46;
            64'h6D756E65:         kw_kind = 7'd47;
            64'h6E7265747865:     kw_kind = 7'd48;
            64'h74616F6C66:       kw_kind = 7'd49;
            64'h726F66:           kw_kind = 7'd50;
            64'h6F746F67:         kw_kind = 7'd51;
            64'h6669:             kw_kind = 7'd52;
            64'h746E69:           kw_kind = 7'd53;
            64'h656E696C6E69:     kw_kind = 7'd54;
            64'h676E6F6C:         kw_kind = 7'd55;
            64'h7265747369676572: kw_kind = 7'd56;
            64'h7463697274736572: kw_kind = 7'd57;
            64'h6E7275746572:     kw_kind = 7'd58;
            64'h74726F6873:       kw_kind = 7'd59;
            64'h64656E676973:     kw_kind = 7'd60;
            64'h666F657A6973:     kw_kind = 7'd61;
            64'h636974617473:     kw_kind = 7'd62;
            64'h746375727473:     kw_kind = 7'd63;
            64'h686374697773:     kw_kind = 7'd64;
            64'h66656465707974:   kw_kind = 7'd65;
            64'h6E6F696E75:       kw_kind = 7'd66;
            64'h64656E6769736E75: kw_kind = 7'd67;
            64'h64696F76:         kw_kind = 7'd68;
            64'h656C6974616C6F76: kw_kind = 7'd69;
            64'h656C696877:       kw_kind = 7'd70;
            default:              kw_kind = KIND_ID;
        endcase
    endfunction

endpackage

[hdl/ctl_front.sv]
// Front end of the C token lexer: accepts bytes, keeps the pending token
// and counters, and emits a group of up to three tokens per byte. Uses ctl_pkg.
module ctl_front #(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 20
) (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic [7:0]      in_byte,
    input  logic            in_last,
    input  logic            in_take,
    output ctl_pkg::group_t grp
);
    import ctl_pkg::*;

    localparam logic [LINE_BITS-1:0]   LINE_MAX = '1;
    localparam logic [OFFSET_BITS-1:0] OFF_MAX  = '1;

    pclass_t                cls_reg, cls_next;
    logic [63:0]            text_reg, text_next;
    logic [3:0]             cnt_reg, cnt_next;
    logic                   ovf_reg, ovf_next;
    logic [LINE_BITS-1:0]   sline_reg, sline_next, line_reg, line_next;
    logic [OFFSET_BITS-1:0] soff_reg, soff_next, boff_reg, boff_next;

    logic       is_dig, is_alp, consumed, do_flush, pend_tok;
    token_t     flush_tok, op_tok, eof_tok;
    logic [6:0] part, single, fkind;
    pclass_t    newcls;
    logic [OFFSET_BITS-1:0] boff_inc;

    function automatic logic [15:0] fit_line(input logic [LINE_BITS-1:0] v);
        logic [47:0] w;
        w = 48'(v);
        fit_line = w[15:0];
    endfunction
    function automatic logic [19:0] fit_off(input logic [OFFSET_BITS-1:0] v);
        logic [51:0] w;
        w = 52'(v);
        fit_off = w[19:0];
    endfunction

    always_comb begin
        is_dig = (in_byte >= 8'h30) && (in_byte <= 8'h39);
        is_alp = ((in_byte >= 8'h61) && (in_byte <= 8'h7A)) ||
                 ((in_byte >= 8'h41) && (in_byte <= 8'h5A));
        // Partner byte of a pending operator: 0x7F means none.
        part = 7'h7F;
        unique case (cls_reg)
            PC_MINUS: part = (in_byte == 8'h3D) ? 7'd5 : (in_byte == 8'h2D) ? 7'd6 : 7'h7F;
            PC_PLUS:  part = (in_byte == 8'h3D) ? 7'd9 : (in_byte == 8'h2B) ? 7'd10 : 7'h7F;
            PC_MUL:   part = (in_byte == 8'h3D) ? 7'd12 : 7'h7F;
            PC_DIV:   part = (in_byte == 8'h3D) ? 7'd14 : 7'h7F;
            PC_MOD:   part = (in_byte == 8'h3D) ? 7'd16 : 7'h7F;
            PC_EQ:    part = (in_byte == 8'h3D) ? 7'd18 : 7'h7F;
            PC_LT:    part = (in_byte == 8'h3D) ? 7'd20 : 7'h7F;
            PC_SHL:   part = (in_byte == 8'h3D) ? 7'd21 : 7'h7F;
            PC_GT:    part = (in_byte == 8'h3D) ? 7'd24 : 7'h7F;
            PC_SHR:   part = (in_byte == 8'h3D) ? 7'd25 : 7'h7F;
            PC_BANG:  part = (in_byte == 8'h3D) ? 7'd28 : 7'h7F;
            PC_AMP:   part = (in_byte == 8'h26) ? 7'd30 : 7'h7F;
            PC_BAR:   part = (in_byte == 8'h7C) ? 7'd32 : 7'h7F;
            default:  part = 7'h7F;
        endcase

        // Pending token as it would be flushed.
        flush_tok = '0;
        flush_tok.line   = fit_line(sline_reg);
        flush_tok.offset = fit_off(soff_reg);
        flush_tok.trunc  = ovf_reg;
        if (cls_reg == PC_NUM || cls_reg == PC_ID) begin
            flush_tok.text = text_reg;
            flush_tok.len  = cnt_reg;
            flush_tok.kind = (cls_reg == PC_NUM) ? KIND_NUM :
                             (ovf_reg ? KIND_ID : kw_kind(text_reg));
        end else begin
            fkind = alone_kind(cls_reg);
            flush_tok.kind = fkind;
            flush_tok.text = 64'(op_text(fkind));
            flush_tok.len  = op_len(fkind);
            flush_tok.trunc = 1'b0;
        end
        fkind = alone_kind(cls_reg);
        pend_tok = (cls_reg != PC_NONE);

        cls_next = cls_reg; text_next = text_reg; cnt_next = cnt_reg;
        ovf_next = ovf_reg; sline_next = sline_reg; soff_next = soff_reg;
        line_next = line_reg;
        consumed = 1'b0; do_flush = 1'b0;
        op_tok = flush_tok;

        if (cls_reg == PC_NUM || cls_reg == PC_ID) begin
            if (is_dig || (cls_reg == PC_ID && (is_alp || in_byte == 8'h5F))) begin
                consumed = 1'b1;
                if (cnt_reg < 4'd8) begin
                    text_next = text_reg | (64'(in_byte) << {cnt_reg[2:0], 3'b000});
                    cnt_next  = cnt_reg + 4'd1;
                end else begin
                    ovf_next = 1'b1;
                end
            end else begin
                do_flush = 1'b1;
            end
        end else if (pend_tok) begin
            if ((cls_reg == PC_LT || cls_reg == PC_GT) && in_byte == {1'b0, 7'(cls_reg == PC_LT ? 7'h3C : 7'h3E)}) begin
                consumed = 1'b1;
                cls_next = (cls_reg == PC_LT) ? PC_SHL : PC_SHR;
            end else if (part != 7'h7F) begin
                consumed = 1'b1;
                do_flush = 1'b1;
                op_tok.kind = part;
                op_tok.text = 64'(op_text(part));
                op_tok.len  = op_len(part);
                op_tok.trunc = 1'b0;
                cls_next = PC_NONE;
            end else begin
                do_flush = 1'b1;
            end
        end
        if (do_flush) cls_next = PC_NONE;

        // Fresh byte.
        single = 7'h7F;
        newcls = PC_NONE;
        if (!consumed) begin
            case (in_byte)
                8'h0A: if (line_reg != LINE_MAX) line_next = line_reg + 1'b1;
                8'h7B: single = 7'd0;   8'h7D: single = 7'd1;
                8'h28: single = 7'd2;   8'h29: single = 7'd3;
                8'h3B: single = 7'd4;   8'h7E: single = 7'd8;
                8'h5E: single = 7'd34;
                8'h2D: newcls = PC_MINUS; 8'h2B: newcls = PC_PLUS;
                8'h2A: newcls = PC_MUL;   8'h2F: newcls = PC_DIV;
                8'h25: newcls = PC_MOD;   8'h3D: newcls = PC_EQ;
                8'h3C: newcls = PC_LT;    8'h3E: newcls = PC_GT;
                8'h21: newcls = PC_BANG;  8'h26: newcls = PC_AMP;
                8'h7C: newcls = PC_BAR;
                default: newcls = is_dig ? PC_NUM : (is_alp ? PC_ID : PC_NONE);
            endcase
            if (newcls != PC_NONE) begin
                cls_next = newcls; text_next = 64'(in_byte); cnt_next = 4'd1;
                ovf_next = 1'b0; sline_next = line_reg; soff_next = boff_reg;
            end
        end
        boff_inc = (boff_reg != OFF_MAX) ? boff_reg + 1'b1 : boff_reg;
        boff_next = boff_inc;

        // Assemble the group in order.
        grp = '0;
        if (do_flush) begin
            grp.t0 = op_tok;
            grp.count = 2'd1;
        end
        if (single != 7'h7F) begin
            token_t s;
            s = '0;
            s.kind = single; s.text = 64'(op_text(single)); s.len = 4'd1;
            s.line = fit_line(line_reg); s.offset = fit_off(boff_reg);
            if (grp.count == 2'd0) grp.t0 = s; else grp.t1 = s;
            grp.count = grp.count + 2'd1;
        end
        if (in_last) begin
            // Flush what remains after this byte, then EOF.
            if (cls_next != PC_NONE) begin
                token_t f;
                f = '0;
                f.line = fit_line(sline_next); f.offset = fit_off(soff_next);
                if (cls_next == PC_NUM || cls_next == PC_ID) begin
                    f.text = text_next; f.len = cnt_next; f.trunc = ovf_next;
                    f.kind = (cls_next == PC_NUM) ? KIND_NUM :
                             (ovf_next ? KIND_ID : kw_kind(text_next));
                end else begin
                    f.kind = alone_kind(cls_next);
                    f.text = 64'(op_text(f.kind)); f.len = op_len(f.kind);
                end
                if (grp.count == 2'd0) grp.t0 = f; else grp.t1 = f;
                grp.count = grp.count + 2'd1;
            end
            eof_tok = '0;
            eof_tok.kind = KIND_EOF; eof_tok.text = 64'h464F45; eof_tok.len = 4'd3;
            eof_tok.line = fit_line(line_next); eof_tok.offset = fit_off(boff_inc);
            case (grp.count)
                2'd0: grp.t0 = eof_tok;
                2'd1: grp.t1 = eof_tok;
                default: grp.t2 = eof_tok;
            endcase
            grp.count = grp.count + 2'd1;
        end else begin
            eof_tok = '0;
        end
        if (!in_take) grp.count = 2'd0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || (in_take && in_last)) begin
            cls_reg <= PC_NONE; text_reg <= '0; cnt_reg <= '0; ovf_reg <= 1'b0;
            sline_reg <= '0; soff_reg <= '0; line_reg <= '0; boff_reg <= '0;
        end else if (in_take) begin
            cls_reg <= cls_next; text_reg <= text_next; cnt_reg <= cnt_next;
            ovf_reg <= ovf_next; sline_reg <= sline_next; soff_reg <= soff_next;
            line_reg <= line_next; boff_reg <= boff_next;
        end
    end

endmodule

[hdl/ctl_back.sv]
// Back end of the C token lexer: a short queue of token groups and
// combinational output logic that hands out one token at a time. Uses ctl_pkg.
module ctl_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  ctl_pkg::group_t grp,
    output logic            room,
    output logic            out_valid,
    input  logic            out_ready,
    output ctl_pkg::token_t out_tok
);
    import ctl_pkg::*;

    localparam int DEPTH = 4;

    group_t     mem [DEPTH];
    logic [1:0] wp_reg, rp_reg;
    logic [2:0] used_reg;
    logic [1:0] sub_reg;
    logic       push, pop;
    group_t     head;
    token_t     cur;
    logic       last_sub;

    assign push = (grp.count != 2'd0);
    assign room = (used_reg < 3'(DEPTH)) || pop;
    assign out_valid = (used_reg != 3'd0);

    always_comb begin
        head = mem[rp_reg];
        case (sub_reg)
            2'd0: cur = head.t0;
            2'd1: cur = head.t1;
            default: cur = head.t2;
        endcase
        last_sub = (sub_reg + 2'd1 == head.count);
        out_tok = cur;
        out_tok.last = last_sub;
        pop = out_valid && out_ready && last_sub;
    end

    always_ff @(posedge aclk) begin
        if (push) mem[wp_reg] <= grp;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; used_reg <= '0; sub_reg <= '0;
        end else begin
            if (push) wp_reg <= wp_reg + 2'd1;
            if (pop) rp_reg <= rp_reg + 2'd1;
            used_reg <= used_reg + 3'(push) - 3'(pop);
            if (out_valid && out_ready) sub_reg <= last_sub ? 2'd0 : sub_reg + 2'd1;
        end
    end

endmodule

[hdl/c_token_lexer.sv]
// Top level of the C token lexer: byte stream in, token stream out.
// Instantiates ctl_front and ctl_back; uses ctl_pkg.
//
//  channel   | direction | tdata                       | tlast
//  s_ bytes  | in        | in_byte[7:0]                | last_byte
//  m_ tokens | out       | kind, text, len, trunc, ... | last of group
//
// One byte request is taken per cycle while the token queue has room.
// Each byte yields zero to three tokens, which leave one per cycle while
// m_tready is high, so a run of multi-token bytes is limited by the output port.
// Reset is synchronous and active low; it clears the lexer and the queue.
// A stall on the output fills the four-group queue, then s_tready falls.
module c_token_lexer #(
    parameter int LINE_BITS   = 16,
    parameter int OFFSET_BITS = 20
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [7:0]   s_tdata,   // in_byte
    input  logic         s_tlast,   // last_byte
    output logic         m_tvalid,
    input  logic         m_tready,
    // kind[6:0], text[70:7], len[74:71], truncated[75], line[91:76],
    // offset[111:92], zero fill [119:112]
    output logic [119:0] m_tdata,
    output logic         m_tlast    // last token of one byte's group
);
    import ctl_pkg::*;

    group_t grp;
    token_t tok;
    logic   take;

    assign take = s_tvalid && s_tready;

    ctl_front #(.LINE_BITS(LINE_BITS), .OFFSET_BITS(OFFSET_BITS)) u_front (
        .aclk(aclk), .aresetn(aresetn), .in_byte(s_tdata), .in_last(s_tlast),
        .in_take(take), .grp(grp)
    );

    ctl_back u_back (
        .aclk(aclk), .aresetn(aresetn), .grp(grp), .room(s_tready),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_tok(tok)
    );

    assign m_tdata = {8'h00, tok.offset, tok.line, tok.trunc, tok.len, tok.text, tok.kind};
    assign m_tlast = tok.last;

endmodule
